FILE: design/itt_pkg.sv
package itt_pkg;

   // Longest token that any limit register may select
   localparam int MAX_TOKEN_LEN = 64;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int REG_W         = 7;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_MAX_SECTION = 2'd0;
   localparam logic [1:0] REG_MAX_KEY     = 2'd1;
   localparam logic [1:0] REG_MAX_VALUE   = 2'd2;

   localparam logic [REG_W-1:0] LIMIT_RESET = REG_W'(MAX_TOKEN_LEN);

   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [3:0] {
      EV_IGNORED    = 4'd0,
      EV_SEC_OPEN   = 4'd1,
      EV_SEC_CHAR   = 4'd2,
      EV_SEC_CLOSE  = 4'd3,
      EV_KEY_CHAR   = 4'd4,
      EV_VAL_CHAR   = 4'd5,
      EV_COMMIT     = 4'd6,
      EV_TOO_LONG   = 4'd7,
      EV_SKIPPED    = 4'd8,
      EV_END_OK     = 4'd9,
      EV_END_COMMIT = 4'd10,
      EV_END_ERR    = 4'd11
   } event_kind_type;

   typedef struct packed {
      logic [REG_W-1:0] section;
      logic [REG_W-1:0] key;
      logic [REG_W-1:0] value;
   } limits_type;

   typedef struct packed {
      event_kind_type   kind;
      logic [7:0]       char_code;
      logic [LEN_W-1:0] length;
   } event_type;

endpackage

FILE: design/itt_if.sv
interface itt_req_if;
   import itt_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       stream_end;

   modport source (output valid, output text_byte, output stream_end, input ready);
   modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

interface itt_rsp_if;
   import itt_pkg::*;

   logic                      valid;
   logic                      ready;
   event_kind_type            event_kind;
   logic [7:0]                event_char;
   logic [REG_W-1:0]          token_length;

   modport source (output valid, output event_kind, output event_char, output token_length,
                   input ready);
   modport sink   (input valid, input event_kind, input event_char, input token_length,
                   output ready);
endinterface

FILE: design/itt_parser.sv
module itt_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         text_byte,
   input  logic               stream_end,
   input  itt_pkg::limits_type limits,
   output itt_pkg::event_type  event_out
);
   import itt_pkg::*;

   typedef enum logic [2:0] {
      SEC_START = 3'd0,
      SEC_NAME  = 3'd1,
      WHITE     = 3'd2,
      KEY       = 3'd3,
      SEP       = 3'd4,
      VALUE     = 3'd5
   } parse_state_type;

   parse_state_type  state_ff, state_in;
   logic             resume_value_ff, resume_value_in;
   logic [LEN_W-1:0] sec_len_ff, sec_len_in;
   logic [LEN_W-1:0] key_len_ff, key_len_in;
   logic [LEN_W-1:0] val_len_ff, val_len_in;
   logic             halted_ff, halted_in;

   logic [LEN_W-1:0] sec_lim, key_lim, val_lim;
   logic             sec_ok, key_ok, val_ok;
   logic [LEN_W-1:0] sec_inc, key_inc, val_inc;
   logic [LEN_W-1:0] key_sat, val_sat;
   logic             is_ws;

   // A zero register acts as one; anything above the ceiling is clamped.
   function automatic logic [LEN_W-1:0] eff_limit(input logic [REG_W-1:0] raw);
      logic [LEN_W-1:0] lim;
      if (raw == '0) begin
         lim = LEN_W'(1);
      end else if (REG_W'(raw) > REG_W'(MAX_TOKEN_LEN)) begin
         lim = LEN_W'(MAX_TOKEN_LEN);
      end else begin
         lim = LEN_W'(raw);
      end
      return lim;
   endfunction

   assign sec_lim = eff_limit(limits.section);
   assign key_lim = eff_limit(limits.key);
   assign val_lim = eff_limit(limits.value);

   assign sec_ok  = sec_len_ff < sec_lim;
   assign key_ok  = key_len_ff < key_lim;
   assign val_ok  = val_len_ff < val_lim;
   assign sec_inc = sec_len_ff + LEN_W'(1);
   assign key_inc = key_len_ff + LEN_W'(1);
   assign val_inc = val_len_ff + LEN_W'(1);

   // After whitespace the first character is kept even at the limit, without growing.
   assign key_sat = key_ok ? key_inc : key_len_ff;
   assign val_sat = val_ok ? val_inc : val_len_ff;

   assign is_ws = (text_byte == CHAR_SPACE) || (text_byte inside {[8'h09:8'h0D]});

   always_comb begin
      state_in        = state_ff;
      resume_value_in = resume_value_ff;
      sec_len_in      = sec_len_ff;
      key_len_in      = key_len_ff;
      val_len_in      = val_len_ff;
      halted_in       = halted_ff;
      event_out       = '{kind: EV_IGNORED, char_code: 8'h00, length: '0};

      if (stream_end) begin
         if (halted_ff) begin
            event_out.kind = EV_END_ERR;
         end else if (state_ff == VALUE) begin
            event_out.kind   = EV_END_COMMIT;
            event_out.length = val_len_ff;
         end else begin
            event_out.kind = EV_END_OK;
         end
         state_in        = SEC_START;
         resume_value_in = 1'b0;
         sec_len_in      = '0;
         key_len_in      = '0;
         val_len_in      = '0;
         halted_in       = 1'b0;
      end else if (halted_ff) begin
         event_out.kind = EV_SKIPPED;
      end else begin
         case (state_ff)
            SEC_START: begin
               if (text_byte == CHAR_OPEN) begin
                  state_in       = SEC_NAME;
                  sec_len_in     = '0;
                  event_out.kind = EV_SEC_OPEN;
               end else if (!is_ws) begin
                  // Every limit is at least one, so the first key character always fits.
                  state_in            = KEY;
                  key_len_in          = LEN_W'(1);
                  val_len_in          = '0;
                  event_out.kind      = EV_KEY_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = LEN_W'(1);
               end
            end
            SEC_NAME: begin
               if (text_byte == CHAR_CLOSE) begin
                  state_in         = WHITE;
                  resume_value_in  = 1'b0;
                  key_len_in       = '0;
                  val_len_in       = '0;
                  event_out.kind   = EV_SEC_CLOSE;
                  event_out.length = sec_len_ff;
               end else if (sec_ok) begin
                  sec_len_in          = sec_inc;
                  event_out.kind      = EV_SEC_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = sec_inc;
               end else begin
                  halted_in        = 1'b1;
                  event_out.kind   = EV_TOO_LONG;
                  event_out.length = sec_len_ff;
               end
            end
            WHITE: begin
               if (is_ws) begin
                  event_out.kind = EV_IGNORED;
               end else if (!resume_value_ff) begin
                  state_in            = KEY;
                  key_len_in          = key_sat;
                  event_out.kind      = EV_KEY_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = key_sat;
               end else begin
                  state_in            = VALUE;
                  val_len_in          = val_sat;
                  event_out.kind      = EV_VAL_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = val_sat;
               end
            end
            KEY: begin
               if (text_byte == CHAR_EQUAL) begin
                  state_in        = WHITE;
                  resume_value_in = 1'b1;
               end else if (is_ws) begin
                  state_in = SEP;
               end else if (key_ok) begin
                  key_len_in          = key_inc;
                  event_out.kind      = EV_KEY_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = key_inc;
               end else begin
                  halted_in        = 1'b1;
                  event_out.kind   = EV_TOO_LONG;
                  event_out.length = key_len_ff;
               end
            end
            SEP: begin
               // The rest of a key after a space is dropped up to the equals sign.
               if (text_byte == CHAR_EQUAL) begin
                  state_in        = WHITE;
                  resume_value_in = 1'b1;
               end
            end
            VALUE: begin
               if (text_byte < CHAR_SPACE) begin
                  event_out.kind   = EV_COMMIT;
                  event_out.length = val_len_ff;
                  state_in         = WHITE;
                  resume_value_in  = 1'b0;
                  key_len_in       = '0;
                  val_len_in       = '0;
               end else if (val_ok) begin
                  val_len_in          = val_inc;
                  event_out.kind      = EV_VAL_CHAR;
                  event_out.char_code = text_byte;
                  event_out.length    = val_inc;
               end else begin
                  halted_in        = 1'b1;
                  event_out.kind   = EV_TOO_LONG;
                  event_out.length = val_len_ff;
               end
            end
            default: begin
               event_out.kind = EV_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SEC_START;
         resume_value_ff <= 1'b0;
         sec_len_ff      <= '0;
         key_len_ff      <= '0;
         val_len_ff      <= '0;
         halted_ff       <= 1'b0;
      end else if (step) begin
         state_ff        <= state_in;
         resume_value_ff <= resume_value_in;
         sec_len_ff      <= sec_len_in;
         key_len_ff      <= key_len_in;
         val_len_ff      <= val_len_in;
         halted_ff       <= halted_in;
      end
   end

endmodule

FILE: design/ini_text_tokenizer.sv
// Channel   Direction  Beat contents
// req_chan  in         text_byte[7:0], stream_end
// rsp_chan  out        event_kind[3:0], event_char[7:0], token_length[6:0]
// csr_*     in/out     APB write/read of max_section_len, max_key_len, max_value_len
//
// Each request beat yields one response beat once it is taken, registered first in an input
// register and then a result register, one beat per cycle while rsp_chan.ready stays high.
// The parse state advances only as the input register hands a beat to the result register.
// Reset is synchronous and active high; the limits return to 64 and the parser to its start.
// A stall on the response side holds the result register, and the input register
// keeps one further beat before req_chan.ready falls.
module ini_text_tokenizer (
   input  logic                              clock,
   input  logic                              reset,
   itt_req_if.sink                           req_chan,
   itt_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [itt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [itt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [itt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import itt_pkg::*;

   limits_type       limits_ff;
   logic [1:0]       csr_index;

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic             out_vld_ff;
   event_type        out_ev_ff;
   event_type        step_ev;
   logic             advance;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_MAX_SECTION: csr_prdata = CSR_DATA_W'(limits_ff.section);
         REG_MAX_KEY:     csr_prdata = CSR_DATA_W'(limits_ff.key);
         REG_MAX_VALUE:   csr_prdata = CSR_DATA_W'(limits_ff.value);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{section: LIMIT_RESET, key: LIMIT_RESET, value: LIMIT_RESET};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            REG_MAX_SECTION: limits_ff.section <= csr_pwdata[REG_W-1:0];
            REG_MAX_KEY:     limits_ff.key     <= csr_pwdata[REG_W-1:0];
            REG_MAX_VALUE:   limits_ff.value   <= csr_pwdata[REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A beat moves into the result register whenever that register is free or being drained.
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!in_vld_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.text_byte;
         in_end_ff  <= req_chan.stream_end;
      end
      if (advance) begin
         out_ev_ff <= step_ev;
      end
   end

   itt_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .text_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .limits     (limits_ff),
      .event_out  (step_ev)
   );

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.event_kind   = out_ev_ff.kind;
   assign rsp_chan.event_char   = out_ev_ff.char_code;
   assign rsp_chan.token_length = out_ev_ff.length;

endmodule

FILE: design/itt_checker.sv
module itt_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input itt_pkg::event_kind_type rsp_event_kind,
   input logic [7:0]              rsp_event_char,
   input logic [6:0]              rsp_token_length
);
   import itt_pkg::*;

   // A result that has been offered stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_event_char) && $stable(rsp_token_length))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // Only the character events carry a character.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_SEC_CHAR && rsp_event_kind != EV_KEY_CHAR
         && rsp_event_kind != EV_VAL_CHAR |-> rsp_event_char == 8'h00)
      else $error("character on a non-character event");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_length <= 7'(MAX_TOKEN_LEN))
      else $error("token length above the ceiling");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_IGNORED || rsp_event_kind == EV_SEC_OPEN
         || rsp_event_kind == EV_SKIPPED || rsp_event_kind == EV_END_OK
         || rsp_event_kind == EV_END_ERR) |-> rsp_token_length == 7'd0)
      else $error("length on an event that carries none");

endmodule

bind ini_text_tokenizer itt_checker u_itt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_event_kind   (rsp_chan.event_kind),
   .rsp_event_char   (rsp_chan.event_char),
   .rsp_token_length (rsp_chan.token_length)
);

FILE: tb/tb_ini_text_tokenizer.sv
module tb_ini_text_tokenizer;
   import itt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BEATS = 110;
   localparam int RANDOM_PHASES = 8;

   // The limit registers occupy indexes 0 to 2; index 3 decodes to nothing.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      PS_SEC_START = 3'd0,
      PS_SEC_NAME  = 3'd1,
      PS_WHITE     = 3'd2,
      PS_KEY       = 3'd3,
      PS_SEP       = 3'd4,
      PS_VALUE     = 3'd5
   } parse_state_type;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } text_beat_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   itt_req_if req_chan ();
   itt_rsp_if rsp_chan ();

   ini_text_tokenizer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_beat_type text_beats[$];
   event_type     expected_events[$];

   // Shadow copy of the limits and the parser state.
   logic [REG_W-1:0] lim_section;
   logic [REG_W-1:0] lim_key;
   logic [REG_W-1:0] lim_value;
   parse_state_type  ps;
   logic             resume_value;
   logic [REG_W-1:0] sec_len;
   logic [REG_W-1:0] key_len;
   logic [REG_W-1:0] val_len;
   logic             halted;

   int  send_idle_pct;
   int  recv_stall_pct;
   int  mismatch_count;
   int  phase_beats;
   int  cycles;
   logic beat_taken;

   always #1 clock = ~clock;

   function automatic logic is_space(logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [REG_W-1:0] clamp_limit(logic [REG_W-1:0] r);
      if (r == 0) return REG_W'(1);
      if (r > MAX_TOKEN_LEN) return REG_W'(MAX_TOKEN_LEN);
      return r;
   endfunction

   // Grows a length by one unless it already sits at its limit.
   function automatic logic [REG_W-1:0] grown(logic [REG_W-1:0] len, logic [REG_W-1:0] r);
      return (len < clamp_limit(r)) ? len + 1'b1 : len;
   endfunction

   function automatic void clear_parser();
      ps = PS_SEC_START;
      resume_value = 1'b0;
      sec_len = '0;
      key_len = '0;
      val_len = '0;
      halted = 1'b0;
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic last);
      event_type ev;
      ev.kind = EV_IGNORED;
      ev.char_code = '0;
      ev.length = '0;
      if (last) begin
         if (halted) begin
            ev.kind = EV_END_ERR;
         end else if (ps == PS_VALUE) begin
            ev.kind = EV_END_COMMIT;
            ev.length = val_len;
         end else begin
            ev.kind = EV_END_OK;
         end
         clear_parser();
      end else if (halted) begin
         ev.kind = EV_SKIPPED;
      end else begin
         case (ps)
            PS_SEC_START: begin
               if (c == CHAR_OPEN) begin
                  ps = PS_SEC_NAME;
                  sec_len = '0;
                  ev.kind = EV_SEC_OPEN;
               end else if (!is_space(c)) begin
                  ps = PS_KEY;
                  val_len = '0;
                  key_len = grown('0, lim_key);
                  ev = '{EV_KEY_CHAR, c, key_len};
               end
            end
            PS_SEC_NAME: begin
               if (c == CHAR_CLOSE) begin
                  ps = PS_WHITE;
                  resume_value = 1'b0;
                  key_len = '0;
                  val_len = '0;
                  ev = '{EV_SEC_CLOSE, 8'h00, sec_len};
               end else if (sec_len < clamp_limit(lim_section)) begin
                  sec_len = sec_len + 1'b1;
                  ev = '{EV_SEC_CHAR, c, sec_len};
               end else begin
                  halted = 1'b1;
                  ev = '{EV_TOO_LONG, 8'h00, sec_len};
               end
            end
            PS_WHITE: begin
               if (is_space(c)) begin
                  ev.kind = EV_IGNORED;
               end else if (!resume_value) begin
                  ps = PS_KEY;
                  key_len = grown(key_len, lim_key);
                  ev = '{EV_KEY_CHAR, c, key_len};
               end else begin
                  ps = PS_VALUE;
                  val_len = grown(val_len, lim_value);
                  ev = '{EV_VAL_CHAR, c, val_len};
               end
            end
            PS_KEY: begin
               if (c == CHAR_EQUAL) begin
                  ps = PS_WHITE;
                  resume_value = 1'b1;
               end else if (is_space(c)) begin
                  ps = PS_SEP;
               end else if (key_len < clamp_limit(lim_key)) begin
                  key_len = key_len + 1'b1;
                  ev = '{EV_KEY_CHAR, c, key_len};
               end else begin
                  halted = 1'b1;
                  ev = '{EV_TOO_LONG, 8'h00, key_len};
               end
            end
            PS_SEP: begin
               if (c == CHAR_EQUAL) begin
                  ps = PS_WHITE;
                  resume_value = 1'b1;
               end
            end
            PS_VALUE: begin
               if (c < 8'h20) begin
                  ev = '{EV_COMMIT, 8'h00, val_len};
                  ps = PS_WHITE;
                  resume_value = 1'b0;
                  key_len = '0;
                  val_len = '0;
               end else if (val_len < clamp_limit(lim_value)) begin
                  val_len = val_len + 1'b1;
                  ev = '{EV_VAL_CHAR, c, val_len};
               end else begin
                  halted = 1'b1;
                  ev = '{EV_TOO_LONG, 8'h00, val_len};
               end
            end
            default: ev.kind = EV_IGNORED;
         endcase
      end
      expected_events = {expected_events, ev};
   endfunction

   task automatic write_limit(input logic [1:0] index, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'({index, 2'b00});
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_MAX_SECTION: lim_section = value;
         REG_MAX_KEY:     lim_key = value;
         REG_MAX_VALUE:   lim_value = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic void add_beat(logic [7:0] c, logic last);
      text_beats = {text_beats, text_beat_type'{c, last}};
      phase_beats++;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
   endfunction

   function automatic logic [REG_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return REG_W'(0);
         1: return REG_W'(1);
         2: return REG_W'(MAX_TOKEN_LEN);
         3: return REG_W'(127);
         4: return REG_W'($urandom_range(2, 16));
         default: return REG_W'($urandom_range(17, 126));
      endcase
   endfunction

   // Mostly short tokens, now and then one exactly at the limit or one past it.
   function automatic int pick_len(logic [REG_W-1:0] r);
      int lim;
      int pct;
      lim = int'(clamp_limit(r));
      pct = $urandom_range(0, 99);
      if (pct < 80) return $urandom_range(1, (lim < 8) ? lim : 8);
      if (pct < 90) return lim;
      return lim + 1;
   endfunction

   function automatic logic [7:0] space_char();
      return ($urandom_range(0, 5) == 0) ? CHAR_SPACE : 8'($urandom_range(9, 13));
   endfunction

   function automatic void add_noise();
      repeat ($urandom_range(1, 4)) add_beat(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // One INI document: optional section, a few key/value lines, then the end beat.
   function automatic void add_document();
      int n;
      int lines;
      logic [7:0] c;
      if ($urandom_range(0, 3) != 0) begin
         add_beat(CHAR_OPEN, 1'b0);
         n = pick_len(lim_section);
         repeat (n) begin
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_CLOSE);
            add_beat(c, 1'b0);
         end
         add_beat(CHAR_CLOSE, 1'b0);
      end
      lines = $urandom_range(1, 5);
      for (int l = 0; l < lines; l++) begin
         if ($urandom_range(0, 7) == 0) add_noise();
         repeat ($urandom_range(0, 2)) add_beat(space_char(), 1'b0);
         n = pick_len(lim_key);
         repeat (n) begin
            do c = 8'($urandom_range(8'h21, 8'hFF));
            while (c == CHAR_EQUAL || c == CHAR_OPEN);
            add_beat(c, 1'b0);
         end
         if ($urandom_range(0, 3) == 0) begin
            add_beat(CHAR_SPACE, 1'b0);
            repeat ($urandom_range(0, 3)) add_beat(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
         end
         if ($urandom_range(0, 9) != 0) add_beat(CHAR_EQUAL, 1'b0);
         repeat ($urandom_range(0, 2)) add_beat(space_char(), 1'b0);
         n = pick_len(lim_value);
         repeat (n) add_beat(8'($urandom_range(8'h20, 8'hFF)), 1'b0);
         // A missing terminator on the last line leaves the value to the end beat.
         if (l < lines - 1 || $urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 3) != 0) add_beat(8'h0A, 1'b0);
            else add_beat(8'($urandom_range(0, 31)), 1'b0);
         end
      end
      add_beat(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   task automatic wait_drained();
      while (text_beats.size() != 0 || expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Driver: a raised valid stays up until its beat is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || beat_taken) begin
         if (text_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.text_byte <= text_beats[0].text;
            req_chan.stream_end <= text_beats[0].last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      beat_taken = 1'b0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         beat_taken = 1'b1;
         tokenize_byte(req_chan.text_byte, req_chan.stream_end);
         void'(text_beats.pop_front());
      end
   end

   // Monitor: each result beat against the oldest expected event.
   always @(posedge clock) begin
      event_type ev;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_events.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: kind %0d char %02h len %0d",
                        rsp_chan.event_kind, rsp_chan.event_char, rsp_chan.token_length);
            mismatch_count++;
         end else begin
            ev = expected_events.pop_front();
            if (rsp_chan.event_kind !== ev.kind || rsp_chan.event_char !== ev.char_code ||
                rsp_chan.token_length !== ev.length) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected kind %0d char %02h len %0d,",
                           ev.kind, ev.char_code, ev.length,
                           " got kind %0d char %02h len %0d", rsp_chan.event_kind,
                           rsp_chan.event_char, rsp_chan.token_length);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ini_text_tokenizer: done, errors");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      cycles = 0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      beat_taken = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.text_byte = '0;
      req_chan.stream_end = 1'b0;
      rsp_chan.ready = 1'b0;
      lim_section = LIMIT_RESET;
      lim_key = LIMIT_RESET;
      lim_value = LIMIT_RESET;
      clear_parser();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: tiny limits so that longer tokens overflow within a few beats.
      write_limit(REG_MAX_SECTION, REG_W'(0));
      write_limit(REG_MAX_KEY, REG_W'(1));
      write_limit(REG_MAX_VALUE, REG_W'(2));
      write_limit(REG_UNUSED, REG_W'(5));
      add_beat(8'h00, 1'b1);
      add_beat(CHAR_SPACE, 1'b0);
      add_text("[a]");
      add_beat(8'h0D, 1'b0);
      add_text("k z=");
      add_beat(8'h09, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h7F, 1'b0);
      add_beat(8'h00, 1'b0);
      add_text("xy[");
      add_beat(8'hFF, 1'b1);
      add_text("[bc");
      add_beat(8'h00, 1'b1);
      add_text("k=pqr");
      add_beat(8'h00, 1'b1);
      add_text("k=v");
      add_beat(8'h00, 1'b1);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         case (ph)
            0: begin
               write_limit(REG_MAX_SECTION, REG_W'(127));
               write_limit(REG_MAX_KEY, REG_W'(127));
               write_limit(REG_MAX_VALUE, REG_W'(127));
            end
            1: begin
               write_limit(REG_MAX_SECTION, REG_W'(1));
               write_limit(REG_MAX_KEY, REG_W'(1));
               write_limit(REG_MAX_VALUE, REG_W'(1));
            end
            2: begin
               write_limit(REG_MAX_SECTION, REG_W'(MAX_TOKEN_LEN));
               write_limit(REG_MAX_KEY, REG_W'(0));
               write_limit(REG_MAX_VALUE, REG_W'(MAX_TOKEN_LEN));
            end
            default: begin
               write_limit(REG_MAX_SECTION, pick_limit());
               write_limit(REG_MAX_KEY, pick_limit());
               write_limit(REG_MAX_VALUE, pick_limit());
            end
         endcase
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) add_document();
         wait_drained();
      end

      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("tb_ini_text_tokenizer: done, clean");
      else
         $display("tb_ini_text_tokenizer: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
design/itt_pkg.sv
design/itt_if.sv
design/itt_parser.sv
design/ini_text_tokenizer.sv
design/itt_checker.sv
tb/tb_ini_text_tokenizer.sv
